FILE: hdl/pfsa_pkg.sv
// package for the paged free-list slot allocator
// holds field widths, status and register codes, sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfsa_pkg;

  // fixed field widths of the stream beats
  localparam int IN_TYPE_W   = 2;
  localparam int IN_PAGE_W   = 3;
  localparam int IN_SLOT_W   = 8;
  localparam int STATUS_W    = 3;
  localparam int OUT_PAGE_W  = 3;
  localparam int OUT_SLOT_W  = 8;
  localparam int OFFSET_W    = 18;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // configuration registers
  localparam int INC_W     = 11;
  localparam int NUM_INC   = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [INC_W-1:0]     INC_RESET  = 11'd32;
  localparam logic [OFFSET_W-1:0]  OFFSET_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_INC_TYPE0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC_TYPE1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INC_TYPE2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INC_TYPE3 = 4'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_RELEASED = 3'd1,
    ST_NO_PAGE  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ACQUIRE = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_MUL,
    S_DONE
  } state_t;

  // sequencer strobes
  typedef struct packed {
    logic accept;
    logic eval;
    logic ram_en;
    logic mul_start;
    logic out_load;
  } seq_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/pfsa_ram.sv
// generic single-port ram with registered read data
// used for the free-slot stacks; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pfsa_mul.sv
// shared shift-add multiplier, one multiplier bit per cycle, msb first
// saturates the product to the offset width; depends on pfsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfsa_mul
  import pfsa_pkg::*;
#(
  parameter int SLOT_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SLOT_W-1:0]   slot,
  input  wire logic [INC_W-1:0]    inc,
  output logic                     done,
  output logic [OFFSET_W-1:0]      offset
);

  localparam int PROD_W = SLOT_W + INC_W;
  localparam int ACC_W  = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;
  localparam int CNT_W  = $clog2(SLOT_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SLOT_W-1:0] mplier_r, mplier_nxt;
  logic [INC_W-1:0]  mcand_r, mcand_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mplier_nxt = slot;
      mcand_nxt  = inc;
    end else if (busy_r) begin
      // acc = 2*acc + bit*inc
      acc_nxt    = {acc_r[ACC_W-2:0], 1'b0}
                 + (mplier_r[SLOT_W-1] ? ACC_W'(mcand_r) : '0);
      mplier_nxt = mplier_r << 1;
      cnt_nxt    = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SLOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
  end

  assign done   = done_r;
  assign offset = (acc_r > ACC_W'(OFFSET_MAX)) ? OFFSET_MAX : acc_r[OFFSET_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/paged_free_list_slot_allocator_unit.sv
// top level of the paged free-list slot allocator
// depends on pfsa_pkg, pfsa_ram (stack storage) and pfsa_mul (offset multiplier)
`timescale 1ns / 1ps
`default_nettype none

// usage
//   in_*  : request beats. in_tuser carries the action (0 acquire, 1 release),
//           in_tdata the heap type, handle flag, page and slot of a release.
//   out_* : one result beat per request, status in out_tuser, granted page,
//           slot and byte offset in out_tdata (all zero unless granted).
//   cfg_* : per-type increment writes, index 0..3, always ready; write only
//           while no request is in flight.
// timing
//   one request at a time; in_tready is high only while the sequencer idles.
//   a grant runs accept, evaluate, an optional stack read, SLOT_W multiplier
//   steps, a finish step and a load step before out_tvalid rises; releases and
//   errors go from evaluate straight to the load step. the multiplier sets the
//   pace.
// reset and stalls
//   reset clears the free counts, low-water marks and open-page counts at once;
//   the stack memory needs no clearing pass since a fresh page is served from
//   its low-water mark until entries are pushed back.
//   a result beat waits in the output register while out_tready is low; the
//   next request can be accepted and evaluated behind it.
module paged_free_list_slot_allocator_unit
  import pfsa_pkg::*;
#(
  parameter int PAGE_SLOTS = 256,
  parameter int MAX_PAGES  = 8,
  parameter int NUM_TYPES  = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] heap_type, [2] handle_valid, [5:3] page_index, [13:6] slot_index
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  wire logic                   in_tuser,
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] granted_page, [10:3] granted_slot, [28:11] byte_offset
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]         out_tuser,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [INC_W-1:0]       cfg_data
);

  localparam int SLOT_W  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(PAGE_SLOTS + 1);
  localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int POPEN_W = $clog2(MAX_PAGES + 1);
  localparam int TYPE_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int NUM_IDX = NUM_TYPES * MAX_PAGES;
  localparam int IDX_W   = (NUM_IDX > 1) ? $clog2(NUM_IDX) : 1;
  localparam int ADDR_W  = TYPE_W + PAGE_W + SLOT_W;

  // sequencer
  state_t    state_r, state_nxt;
  seq_ctrl_t ctl;

  // latched request
  action_t                act_r;
  logic [IN_TYPE_W-1:0]   type_r;
  logic                   hv_r;
  logic [IN_PAGE_W-1:0]   page_in_r;
  logic [IN_SLOT_W-1:0]   slot_in_r;

  // per page / per type bookkeeping
  logic [CNT_W-1:0]   counts_r [NUM_IDX];
  logic [CNT_W-1:0]   lwm_r    [NUM_IDX];
  logic [POPEN_W-1:0] popen_r  [NUM_TYPES];
  logic [INC_W-1:0]   inc_r    [NUM_INC];

  // evaluate results
  status_t            st_r;
  logic [PAGE_W-1:0]  pg_r;
  logic [SLOT_W-1:0]  slot_r;

  status_t            ev_status;
  logic [TYPE_W-1:0]  tsel;
  logic [PAGE_W-1:0]  ev_pg;
  logic [IDX_W-1:0]   ev_idx;
  logic [CNT_W-1:0]   ev_cnt_new;
  logic [CNT_W-1:0]   ev_lwm_new;
  logic               ev_upd;
  logic               ev_open;
  logic               ev_we;
  logic               ev_use_init;
  logic [SLOT_W-1:0]  ev_pos;
  logic [SLOT_W-1:0]  ev_init_slot;

  logic [SLOT_W-1:0]  ram_rdata;
  logic               mul_done;
  logic [OFFSET_W-1:0] mul_offset;
  logic [SLOT_W-1:0]  mul_slot;

  // output register
  logic                 out_tvalid_r;
  status_t              out_status_r;
  logic [OUT_PAGE_W-1:0] out_page_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic [OFFSET_W-1:0]  out_offset_r;

  // request decode and page search, evaluated in S_EVAL
  always_comb begin
    logic               type_ok;
    logic [POPEN_W-1:0] popen;
    logic               any;
    logic [PAGE_W-1:0]  found;
    logic [CNT_W-1:0]   cnt_cur;
    logic [CNT_W-1:0]   lwm_cur;
    logic [IDX_W-1:0]   pidx;
    logic               bad;

    type_ok = 32'(type_r) < NUM_TYPES;
    tsel    = type_ok ? TYPE_W'(type_r) : '0;
    popen   = popen_r[tsel];
    any     = 1'b0;
    found   = '0;
    bad     = 1'b0;
    // lowest page of the type with a free slot
    for (int p = MAX_PAGES - 1; p >= 0; p--) begin
      pidx = IDX_W'(32'(tsel) * MAX_PAGES + p);
      if (counts_r[pidx] != '0 && 32'(p) < 32'(popen)) begin
        any   = 1'b1;
        found = PAGE_W'(p);
      end
    end

    ev_status    = ST_IGNORED;
    ev_pg        = '0;
    ev_upd       = 1'b0;
    ev_open      = 1'b0;
    ev_we        = 1'b0;
    ev_use_init  = 1'b0;
    cnt_cur      = '0;
    lwm_cur      = '0;
    ev_cnt_new   = '0;
    ev_lwm_new   = '0;
    ev_pos       = '0;
    ev_init_slot = '0;

    if (act_r == ACT_ACQUIRE) begin
      ev_pg = any ? found : PAGE_W'(popen);
    end else begin
      ev_pg = PAGE_W'(page_in_r);
    end
    ev_idx  = IDX_W'(32'(tsel) * MAX_PAGES + 32'(ev_pg));
    cnt_cur = counts_r[ev_idx];
    lwm_cur = lwm_r[ev_idx];

    if (act_r == ACT_ACQUIRE) begin
      if (!type_ok) begin
        ev_status = ST_NO_PAGE;
      end else if (!any && 32'(popen) >= MAX_PAGES) begin
        ev_status = ST_NO_PAGE;
      end else begin
        ev_status = ST_GRANTED;
        ev_upd    = 1'b1;
        if (!any) begin
          // fresh page: full stack, untouched down to the bottom
          ev_open = 1'b1;
          cnt_cur = CNT_W'(PAGE_SLOTS);
          lwm_cur = CNT_W'(PAGE_SLOTS);
        end
        ev_cnt_new   = cnt_cur - CNT_W'(1);
        ev_use_init  = ev_cnt_new < lwm_cur;
        ev_lwm_new   = ev_use_init ? ev_cnt_new : lwm_cur;
        ev_pos       = ev_cnt_new[SLOT_W-1:0];
        ev_init_slot = SLOT_W'(PAGE_SLOTS - 1) - ev_cnt_new[SLOT_W-1:0];
      end
    end else begin
      bad = !type_ok || !hv_r || 32'(page_in_r) >= MAX_PAGES
         || 32'(page_in_r) >= 32'(popen) || 32'(slot_in_r) >= PAGE_SLOTS;
      if (bad) begin
        ev_status = ST_IGNORED;
      end else if (cnt_cur >= CNT_W'(PAGE_SLOTS)) begin
        ev_status = ST_FULL;
      end else begin
        ev_status  = ST_RELEASED;
        ev_upd     = 1'b1;
        ev_we      = 1'b1;
        ev_cnt_new = cnt_cur + CNT_W'(1);
        ev_lwm_new = lwm_cur;
        ev_pos     = cnt_cur[SLOT_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (ev_status != ST_GRANTED) begin
          state_nxt = S_DONE;
        end else if (ev_use_init) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: ctl.accept = in_tvalid;
      S_EVAL: begin
        ctl.eval      = 1'b1;
        ctl.ram_en    = (ev_status == ST_GRANTED && !ev_use_init) || ev_we;
        ctl.mul_start = ev_status == ST_GRANTED && ev_use_init;
      end
      S_READ: ctl.mul_start = 1'b1;
      S_MUL:  ctl = '0;
      S_DONE: ctl.out_load = !out_tvalid_r || out_tready;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      act_r     <= action_t'(in_tuser);
      type_r    <= in_tdata[1:0];
      hv_r      <= in_tdata[2];
      page_in_r <= in_tdata[5:3];
      slot_in_r <= in_tdata[13:6];
    end
  end

  // bookkeeping updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_IDX; i++) begin
        counts_r[i] <= '0;
        lwm_r[i]    <= '0;
      end
      for (int t = 0; t < NUM_TYPES; t++) begin
        popen_r[t] <= '0;
      end
    end else if (ctl.eval) begin
      if (ev_upd) begin
        counts_r[ev_idx] <= ev_cnt_new;
        lwm_r[ev_idx]    <= ev_lwm_new;
      end
      if (ev_open) begin
        popen_r[tsel] <= popen_r[tsel] + POPEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      st_r <= ev_status;
      pg_r <= ev_pg;
    end
    if (ctl.mul_start) begin
      slot_r <= mul_slot;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INC; i++) begin
        inc_r[i] <= INC_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INC_TYPE0: inc_r[0] <= cfg_data;
        REG_INC_TYPE1: inc_r[1] <= cfg_data;
        REG_INC_TYPE2: inc_r[2] <= cfg_data;
        REG_INC_TYPE3: inc_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stack storage, addressed {type, page, position}
  pfsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (2 ** ADDR_W)
  ) u_stack_ram (
    .clk   (clk),
    .en    (ctl.ram_en),
    .we    (ev_we),
    .addr  ({tsel, ev_pg, ev_pos}),
    .wdata (SLOT_W'(slot_in_r)),
    .rdata (ram_rdata)
  );

  // slot from the untouched part of the stack or from memory
  assign mul_slot = (state_r == S_READ) ? ram_rdata : ev_init_slot;

  pfsa_mul #(
    .SLOT_W (SLOT_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.mul_start),
    .slot   (mul_slot),
    .inc    (inc_r[type_r]),
    .done   (mul_done),
    .offset (mul_offset)
  );

  // output register, frees the sequencer while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= st_r;
      if (st_r == ST_GRANTED) begin
        out_page_r   <= OUT_PAGE_W'(pg_r);
        out_slot_r   <= OUT_SLOT_W'(slot_r);
        out_offset_r <= mul_offset;
      end else begin
        out_page_r   <= '0;
        out_slot_r   <= '0;
        out_offset_r <= '0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_offset_r, out_slot_r, out_page_r};

`ifndef SYNTH
  // the untouched region never lies above the stack top
  ap_lwm_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> lwm_r[ev_idx] <= counts_r[ev_idx])
    else $error("low-water mark above free count");

  ap_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> counts_r[ev_idx] <= CNT_W'(PAGE_SLOTS))
    else $error("free count beyond page size");

  ap_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside of its step");

  ap_grant_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> 32'(pg_r) < 32'(popen_r[tsel]))
    else $error("grant from a page that is not open");

  ap_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load && st_r != ST_GRANTED |=> out_tdata == '0)
    else $error("non-grant result carries data");
`endif

endmodule

`default_nettype wire
